>>> design/battery_undervoltage_monitor_top_macros.svh
// ----------------------------------------------------------------------------
// battery_undervoltage_monitor_top_macros
// Assertion macros used by the checker file of the monitor.
// ----------------------------------------------------------------------------
`ifndef BATTERY_UNDERVOLTAGE_MONITOR_TOP_MACROS_SVH
`define BATTERY_UNDERVOLTAGE_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BUM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bum assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BUM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bum assertion failed");

`endif

>>> design/bum_pkg.sv
// ----------------------------------------------------------------------------
// bum_pkg
// Types and constants of the battery undervoltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bum_pkg;

	// Ticks between two window checks
	localparam logic [7:0]  CHECK_PERIOD = 8'd200;
	// In-window checks that raise the alarm
	localparam logic [3:0]  HIT_LIMIT    = 4'd10;
	// Filter weight, 26/256 for 0.1
	localparam logic [4:0]  FILTER_GAIN  = 5'd26;
	// Largest level the filter can reach (4095 << 8)
	localparam logic [19:0] LEVEL_MAX    = 20'hFFF00;

	// Register reset values
	localparam logic        ALARM_ENABLE_RST = 1'b1;
	localparam logic [19:0] UPPER_THR_RST    = 20'd320512;
	localparam logic [19:0] LOWER_THR_RST    = 20'd173312;

	// Register indexes
	localparam logic [1:0] REG_ALARM_ENABLE = 2'd0;
	localparam logic [1:0] REG_UPPER_THR    = 2'd1;
	localparam logic [1:0] REG_LOWER_THR    = 2'd2;

	// Item operations
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic        op;
		logic [11:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic [19:0] filtered_level;
		logic        alarm;
		logic [3:0]  low_count;
	} out_item_t;

endpackage

`default_nettype wire

>>> design/battery_undervoltage_monitor_top.sv
// ----------------------------------------------------------------------------
// battery_undervoltage_monitor_top
// IIR-filtered battery level with a windowed undervoltage check and alarm.
// ----------------------------------------------------------------------------
//  channel | signals                         | accepted when
//  --------+---------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_item     | in_valid && in_ready
//  output  | out_valid, out_ready, out_item  | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data     | cfg_we (no wait, no read-back)
//
//  One item per cycle sustained while the output does not stall; a result is
//  valid once its item moves from stage 1 into the result register, where the
//  filter, prescaler and window counter update in one pass. Stage 1 holds the
//  accepted item. A stall on the output holds both stages; in_ready drops only
//  when both are full. Reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_undervoltage_monitor_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bum_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output bum_pkg::out_item_t    out_item,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [19:0]      cfg_data
);
	import bum_pkg::*;

	// configuration registers
	logic        alarm_enable_q;
	logic [19:0] upper_thr_q;
	logic [19:0] lower_thr_q;

	// block state
	logic [19:0] level_q;
	logic [7:0]  prescaler_q;
	logic [3:0]  window_cnt_q;

	// pipeline
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	logic      advance;

	// next-state logic
	logic [19:0] target;
	logic [19:0] diff;
	logic [24:0] prod;
	logic [19:0] level_nx;
	logic [7:0]  pre_inc;
	logic [7:0]  prescaler_nx;
	logic [3:0]  cnt_chk;
	logic [3:0]  window_cnt_nx;
	logic        alarm_nx;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enable_q <= ALARM_ENABLE_RST;
			upper_thr_q    <= UPPER_THR_RST;
			lower_thr_q    <= LOWER_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALARM_ENABLE: alarm_enable_q <= cfg_data[0];
				REG_UPPER_THR:    upper_thr_q    <= cfg_data;
				REG_LOWER_THR:    lower_thr_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// filter step toward the sample, floor rounding in both directions
	always_comb begin
		target = {item_s1.adc_sample, 8'h00};
		if (target >= level_q) begin
			diff     = target - level_q;
			prod     = 25'(diff) * 25'(FILTER_GAIN);
			level_nx = level_q + 20'(prod[24:8]);
		end else begin
			diff     = level_q - target;
			prod     = 25'(diff) * 25'(FILTER_GAIN) + 25'd255;
			level_nx = level_q - 20'(prod[24:8]);
		end
	end

	// prescaler and window check on a tick
	always_comb begin
		pre_inc       = prescaler_q + 8'd1;
		prescaler_nx  = pre_inc;
		cnt_chk       = window_cnt_q;
		window_cnt_nx = window_cnt_q;
		alarm_nx      = 1'b0;
		if (pre_inc >= CHECK_PERIOD) begin
			prescaler_nx = 8'd0;
			if (level_q < upper_thr_q && level_q > lower_thr_q) begin
				cnt_chk = window_cnt_q + 4'd1;
			end else begin
				cnt_chk = window_cnt_q >> 1;
			end
			window_cnt_nx = cnt_chk;
			if (cnt_chk >= HIT_LIMIT) begin
				window_cnt_nx = 4'd0;
				alarm_nx      = alarm_enable_q;
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// capture input item
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// update state as the item passes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= 20'd0;
			prescaler_q  <= 8'd0;
			window_cnt_q <= 4'd0;
		end else if (advance) begin
			case (item_s1.op)
				OP_SAMPLE: level_q <= level_nx;
				OP_TICK: begin
					prescaler_q  <= prescaler_nx;
					window_cnt_q <= window_cnt_nx;
				end
				default: ;
			endcase
		end
	end

	// load result register
	always_ff @(posedge clk) begin
		if (advance) begin
			case (item_s1.op)
				OP_SAMPLE: begin
					item_s2.filtered_level <= level_nx;
					item_s2.alarm          <= 1'b0;
					item_s2.low_count      <= window_cnt_q;
				end
				OP_TICK: begin
					item_s2.filtered_level <= level_q;
					item_s2.alarm          <= alarm_nx;
					item_s2.low_count      <= window_cnt_nx;
				end
				default: begin
					item_s2.filtered_level <= level_q;
					item_s2.alarm          <= 1'b0;
					item_s2.low_count      <= window_cnt_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/bum_checker.sv
// ----------------------------------------------------------------------------
// bum_checker
// Port-level checks of the battery undervoltage monitor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_undervoltage_monitor_top_macros.svh"

module bum_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire bum_pkg::in_item_t  in_item,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bum_pkg::out_item_t out_item,
	input wire logic               cfg_we,
	input wire logic [1:0]         cfg_index,
	input wire logic [19:0]        cfg_data
);
	import bum_pkg::*;

	logic out_stall;
	logic unused_in;

	assign out_stall = out_valid && !out_ready;
	assign unused_in = in_valid ^ in_ready ^ (^in_item) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

	// hold a stalled result
	`BUM_ASSERT_NEXT(a_out_hold_valid, out_stall, out_valid)
	`BUM_ASSERT_NEXT(a_out_hold_item, out_stall, $stable(out_item))
	// an alarm item clears the window counter
	`BUM_ASSERT_NOW(a_alarm_clears, out_valid && out_item.alarm, out_item.low_count == 4'd0)
	// counter never shows the limit
	`BUM_ASSERT_NOW(a_count_below_limit, out_valid, out_item.low_count < HIT_LIMIT)
	// filter stays within the sample range
	`BUM_ASSERT_NOW(a_level_range, out_valid, out_item.filtered_level <= LEVEL_MAX)

endmodule

bind battery_undervoltage_monitor_top bum_checker u_bum_checker (.*);

`default_nettype wire
